[sv/ycbc_pkg.sv]
// Shared types, widths and constants for the YUYV color blob centroid block.
// Used by every module under sv/; depends on nothing.
package ycbc_pkg;

    // Frame geometry limits
    localparam int MAX_PAIRS_PER_ROW = 1024;
    localparam int MAX_LINES         = 2048;

    localparam int PPR_W   = 11;                          // pairs_per_row register
    localparam int LPF_W   = 12;                          // lines_per_frame register
    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_PAIRS_PER_ROW);   // pair index within a row
    localparam int ROW_W   = $clog2(MAX_LINES);           // row index within a frame
    localparam int POS_W   = 11;
    localparam int SUM_W   = 33;
    localparam int CNT_W   = 23;
    localparam int AREA_W  = 23;                          // pixels in a frame
    localparam int FLOOR_W = 17;                          // area / 100
    localparam int QBIT_W  = 4;                           // counts quotient bits

    // area / 100 as (area * RECIP_100) >> RECIP_SHIFT, exact for area < 2**23
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIRS_PER_ROW    = 3'd0,
        CFG_LINES_PER_FRAME  = 3'd1,
        CFG_U_REF            = 3'd2,
        CFG_V_REF            = 3'd3,
        CFG_CHROMA_TOLERANCE = 3'd4,
        CFG_LUMA_MIN         = 3'd5,
        CFG_LUMA_MAX         = 3'd6
    } t_cfg_idx;

    // Color window shared by both pixel lanes
    typedef struct packed {
        logic [PIX_W-1:0] u_ref;
        logic [PIX_W-1:0] v_ref;
        logic [PIX_W-1:0] chroma_tolerance;
        logic [PIX_W-1:0] luma_min;
        logic [PIX_W-1:0] luma_max;
    } t_color_window;

    // Frozen totals of a finished frame, handed to the divider
    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0] count;
        logic [PPR_W-1:0] ppr;
        logic [LPF_W-1:0] lpf;
    } t_frame_totals;

endpackage

[sv/yuyv_color_blob_centroid_top.sv]
// Top level of the YUYV color blob centroid block: configuration registers,
// two pixel lanes, merge/accumulate stage and end-of-frame divider.
// Depends on ycbc_pkg, ycbc_lane, ycbc_accum, ycbc_div.
//
// Usage:
//   Input channel (i_valid/o_ready): one word per YUYV pixel pair, raster order;
//   i_frame_start marks the first pair of a frame. Pairs are taken one per
//   cycle while o_ready is high. Output channel (o_valid/i_ready): one word per
//   frame (found, pos_x, pos_y), issued after the last pair of the frame.
//   Config channel (i_cfg_valid/o_cfg_ready): always ready; writes register
//   i_cfg_index with i_cfg_data, truncated to the register width.
// Result path: area multiply, reciprocal scale, 11 quotient-bit divider steps,
//   then load into the output register.
// Throughput: one pair per cycle while o_ready is high. The divider serves one
//   frame at a time, so the last pair of the next frame waits while it is
//   still busy.
// Receiver stall: the finished result holds in the output register and the
//   divider holds its next result until the register frees; input pairs that
//   do not close a frame keep flowing meanwhile.
// Reset: geometry 320 pairs x 480 lines, chroma window 90/90 +-30, luma 40..235;
//   position, sums and count cleared; no result pending.
module yuyv_color_blob_centroid_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ycbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ycbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_frame_start,
    input  logic [ycbc_pkg::PIX_W-1:0]      i_luma_even,
    input  logic [ycbc_pkg::PIX_W-1:0]      i_chroma_u,
    input  logic [ycbc_pkg::PIX_W-1:0]      i_luma_odd,
    input  logic [ycbc_pkg::PIX_W-1:0]      i_chroma_v,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_found,
    output logic [ycbc_pkg::POS_W-1:0]      o_pos_x,
    output logic [ycbc_pkg::POS_W-1:0]      o_pos_y
);
    import ycbc_pkg::*;

    logic [PPR_W-1:0] r_pairs_per_row;
    logic [LPF_W-1:0] r_lines_per_frame;
    t_color_window    r_window;

    logic          match_even;
    logic          match_odd;
    logic          frame_end;
    logic          div_busy;
    logic          accept;
    t_frame_totals totals;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs_per_row           <= PPR_W'(320);
            r_lines_per_frame         <= LPF_W'(480);
            r_window.u_ref            <= PIX_W'(90);
            r_window.v_ref            <= PIX_W'(90);
            r_window.chroma_tolerance <= PIX_W'(30);
            r_window.luma_min         <= PIX_W'(40);
            r_window.luma_max         <= PIX_W'(235);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAIRS_PER_ROW:    r_pairs_per_row           <= i_cfg_data[PPR_W-1:0];
                CFG_LINES_PER_FRAME:  r_lines_per_frame         <= i_cfg_data[LPF_W-1:0];
                CFG_U_REF:            r_window.u_ref            <= i_cfg_data[PIX_W-1:0];
                CFG_V_REF:            r_window.v_ref            <= i_cfg_data[PIX_W-1:0];
                CFG_CHROMA_TOLERANCE: r_window.chroma_tolerance <= i_cfg_data[PIX_W-1:0];
                CFG_LUMA_MIN:         r_window.luma_min         <= i_cfg_data[PIX_W-1:0];
                CFG_LUMA_MAX:         r_window.luma_max         <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    ycbc_lane u_lane_even (
        .i_luma     (i_luma_even),
        .i_chroma_u (i_chroma_u),
        .i_chroma_v (i_chroma_v),
        .i_window   (r_window),
        .o_match    (match_even)
    );

    ycbc_lane u_lane_odd (
        .i_luma     (i_luma_odd),
        .i_chroma_u (i_chroma_u),
        .i_chroma_v (i_chroma_v),
        .i_window   (r_window),
        .o_match    (match_odd)
    );

    // hold only a frame-closing word while the divider still works
    assign o_ready = !(div_busy && frame_end);
    assign accept  = i_valid && o_ready;

    ycbc_accum u_accum (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_frame_start     (i_frame_start),
        .i_match_even      (match_even),
        .i_match_odd       (match_odd),
        .i_pairs_per_row   (r_pairs_per_row),
        .i_lines_per_frame (r_lines_per_frame),
        .o_frame_end       (frame_end),
        .o_totals          (totals)
    );

    ycbc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept && frame_end),
        .i_totals (totals),
        .o_busy   (div_busy),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_found  (o_found),
        .o_pos_x  (o_pos_x),
        .o_pos_y  (o_pos_y)
    );

endmodule

[sv/ycbc_lane.sv]
// One pixel lane: luma window and chroma distance test for a single pixel.
// Depends on ycbc_pkg.
module ycbc_lane (
    input  logic [ycbc_pkg::PIX_W-1:0] i_luma,
    input  logic [ycbc_pkg::PIX_W-1:0] i_chroma_u,
    input  logic [ycbc_pkg::PIX_W-1:0] i_chroma_v,
    input  ycbc_pkg::t_color_window    i_window,
    output logic                       o_match
);
    import ycbc_pkg::*;

    logic [PIX_W-1:0] dist_u;
    logic [PIX_W-1:0] dist_v;
    logic             luma_ok;

    always_comb begin
        dist_u = (i_chroma_u >= i_window.u_ref) ? i_chroma_u - i_window.u_ref
                                                : i_window.u_ref - i_chroma_u;
        dist_v = (i_chroma_v >= i_window.v_ref) ? i_chroma_v - i_window.v_ref
                                                : i_window.v_ref - i_chroma_v;
        luma_ok = (i_luma >= i_window.luma_min) && (i_luma <= i_window.luma_max);
        o_match = luma_ok && (dist_u <= i_window.chroma_tolerance)
                          && (dist_v <= i_window.chroma_tolerance);
    end

endmodule

[sv/ycbc_accum.sv]
// Merge stage: combines the two lane matches into running column/row sums and
// a match count, and tracks raster position. Depends on ycbc_pkg.
module ycbc_accum (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_frame_start,
    input  logic                       i_match_even,
    input  logic                       i_match_odd,
    input  logic [ycbc_pkg::PPR_W-1:0] i_pairs_per_row,
    input  logic [ycbc_pkg::LPF_W-1:0] i_lines_per_frame,
    output logic                       o_frame_end,
    output ycbc_pkg::t_frame_totals    o_totals
);
    import ycbc_pkg::*;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [SUM_W-1:0] r_sum_x;
    logic [SUM_W-1:0] r_sum_y;
    logic [CNT_W-1:0] r_count;

    logic [COL_W-1:0] base_col;
    logic [ROW_W-1:0] base_row;
    logic [SUM_W-1:0] base_sum_x;
    logic [SUM_W-1:0] base_sum_y;
    logic [CNT_W-1:0] base_count;
    logic [PPR_W-1:0] ppr_c;
    logic [LPF_W-1:0] lpf_c;
    logic [POS_W:0]   add_x;
    logic [ROW_W:0]   add_y;
    logic [PPR_W-1:0] col_inc;
    logic [LPF_W-1:0] row_inc;
    logic             row_last;
    logic [SUM_W-1:0] n_sum_x;
    logic [SUM_W-1:0] n_sum_y;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        // clamp geometry to the supported range
        if (i_pairs_per_row == '0)
            ppr_c = PPR_W'(1);
        else if (i_pairs_per_row > PPR_W'(MAX_PAIRS_PER_ROW))
            ppr_c = PPR_W'(MAX_PAIRS_PER_ROW);
        else
            ppr_c = i_pairs_per_row;
        if (i_lines_per_frame == '0)
            lpf_c = LPF_W'(1);
        else if (i_lines_per_frame > LPF_W'(MAX_LINES))
            lpf_c = LPF_W'(MAX_LINES);
        else
            lpf_c = i_lines_per_frame;

        // a frame start restarts at pair 0 of row 0 with empty sums
        base_col   = i_frame_start ? '0 : r_col;
        base_row   = i_frame_start ? '0 : r_row;
        base_sum_x = i_frame_start ? '0 : r_sum_x;
        base_sum_y = i_frame_start ? '0 : r_sum_y;
        base_count = i_frame_start ? '0 : r_count;

        add_x = (i_match_even ? {1'b0, base_col, 1'b0} : '0)
              + (i_match_odd  ? {1'b0, base_col, 1'b1} : '0);
        add_y = (i_match_even ? {1'b0, base_row} : '0)
              + (i_match_odd  ? {1'b0, base_row} : '0);

        n_sum_x = base_sum_x + SUM_W'(add_x);
        n_sum_y = base_sum_y + SUM_W'(add_y);
        n_count = base_count + CNT_W'(i_match_even) + CNT_W'(i_match_odd);

        col_inc     = PPR_W'(base_col) + PPR_W'(1);
        row_inc     = LPF_W'(base_row) + LPF_W'(1);
        row_last    = col_inc >= ppr_c;
        o_frame_end = row_last && (row_inc >= lpf_c);

        o_totals.sum_x = n_sum_x;
        o_totals.sum_y = n_sum_y;
        o_totals.count = n_count;
        o_totals.ppr   = ppr_c;
        o_totals.lpf   = lpf_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            if (o_frame_end) begin
                // totals go to the divider; start the next frame clean
                r_col   <= '0;
                r_row   <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_count <= '0;
            end else begin
                r_col   <= row_last ? '0 : col_inc[COL_W-1:0];
                r_row   <= row_last ? row_inc[ROW_W-1:0] : base_row;
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_count <= n_count;
            end
        end
    end

endmodule

[sv/ycbc_div.sv]
// End-of-frame unit: match threshold (area / 100 by reciprocal), two restoring
// dividers for the mean x and y, and the result register. Depends on ycbc_pkg.
module ycbc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  ycbc_pkg::t_frame_totals    i_totals,
    output logic                       o_busy,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_found,
    output logic [ycbc_pkg::POS_W-1:0] o_pos_x,
    output logic [ycbc_pkg::POS_W-1:0] o_pos_y
);
    import ycbc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_AREA  = 5'b00010,
        S_SCALE = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_div_state;

    localparam int DSH_W  = CNT_W + POS_W;
    localparam int PROD_W = AREA_W + RECIP_W;

    t_div_state r_state, n_state;
    logic       r_out_valid;

    logic [PPR_W-1:0]   r_ppr;
    logic [LPF_W-1:0]   r_lpf;
    logic [AREA_W-1:0]  r_area;
    logic [FLOOR_W-1:0] r_floor;
    logic [CNT_W-1:0]   r_count;
    logic [DSH_W-1:0]   r_dsh;
    logic [DSH_W-1:0]   r_rem_x;
    logic [DSH_W-1:0]   r_rem_y;
    logic [POS_W-1:0]   r_q_x;
    logic [POS_W-1:0]   r_q_y;
    logic [QBIT_W-1:0]  r_bit;
    logic               r_found;
    logic [POS_W-1:0]   r_pos_x;
    logic [POS_W-1:0]   r_pos_y;

    logic [AREA_W-1:0] area_prod;
    logic [PROD_W-1:0] scaled;
    logic              ge_x;
    logic              ge_y;
    logic              found;
    logic              load_out;

    always_comb begin
        area_prod = {{(AREA_W-PPR_W){1'b0}}, r_ppr} * {{(AREA_W-LPF_W){1'b0}}, r_lpf};
        scaled    = {{RECIP_W{1'b0}}, r_area} * {{AREA_W{1'b0}}, RECIP_100};
        ge_x      = r_rem_x >= r_dsh;
        ge_y      = r_rem_y >= r_dsh;
        found     = r_count > CNT_W'(r_floor);
        load_out  = (r_state == S_DONE) && (!r_out_valid || i_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_AREA;
            S_AREA:  n_state = S_SCALE;
            S_SCALE: n_state = S_DIV;
            S_DIV:   if (r_bit == '0) n_state = S_DONE;
            S_DONE:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)
                r_out_valid <= 1'b1;
            else if (i_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_ppr   <= i_totals.ppr;
            r_lpf   <= i_totals.lpf;
            r_count <= i_totals.count;
            r_rem_x <= DSH_W'(i_totals.sum_x);
            r_rem_y <= DSH_W'(i_totals.sum_y);
        end
        if (r_state == S_AREA)
            r_area <= {area_prod[AREA_W-2:0], 1'b0};
        if (r_state == S_SCALE) begin
            r_floor <= scaled[RECIP_SHIFT +: FLOOR_W];
            r_dsh   <= {r_count, {POS_W{1'b0}}} >> 1;
            r_bit   <= QBIT_W'(POS_W - 1);
        end
        // one quotient bit per cycle for both axes
        if (r_state == S_DIV) begin
            if (ge_x) r_rem_x <= r_rem_x - r_dsh;
            if (ge_y) r_rem_y <= r_rem_y - r_dsh;
            r_q_x <= {r_q_x[POS_W-2:0], ge_x};
            r_q_y <= {r_q_y[POS_W-2:0], ge_y};
            r_dsh <= r_dsh >> 1;
            r_bit <= r_bit - QBIT_W'(1);
        end
        if (load_out) begin
            r_found <= found;
            r_pos_x <= found ? r_q_x : '0;
            r_pos_y <= found ? r_q_y : '0;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_found = r_found;
    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;

endmodule
